FILE: rtl/irc_message_tokenizer_defines.svh
// Assertion helpers used by the tokenizer output stage.
`ifndef IRC_MESSAGE_TOKENIZER_DEFINES_SVH
`define IRC_MESSAGE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IRC_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IRC_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: rtl/irc_tok_pkg.sv
package irc_tok_pkg;

   localparam int MAX_PARAMS = 16;
   localparam int IDX_LIMIT_INT = ((MAX_PARAMS - 1) > 15) ? 15 : (MAX_PARAMS - 1);
   localparam logic [3:0] IDX_LIMIT = IDX_LIMIT_INT[3:0];

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [5:0] {
      PH_START   = 6'b000001,
      PH_PREFIX  = 6'b000010,
      PH_COMMAND = 6'b000100,
      PH_PARAM   = 6'b001000,
      PH_TRAIL   = 6'b010000,
      PH_BAD     = 6'b100000
   } phase_type;

   typedef enum logic [1:0] {
      EV_CONTENT = 2'd0,
      EV_CLOSE   = 2'd1,
      EV_DROP    = 2'd2,
      EV_END     = 2'd3
   } evt_type;

   typedef enum logic [1:0] {
      FLD_PREFIX  = 2'd0,
      FLD_COMMAND = 2'd1,
      FLD_PARAM   = 2'd2,
      FLD_TRAIL   = 2'd3
   } fld_type;

   typedef struct packed {
      logic [7:0] data;
      evt_type    evt;
      fld_type    fld;
      logic [3:0] idx;
      logic       malformed;
      logic       overflow;
      logic       eor;
   } result_type;

   // everything one byte produces: its own result and, on the last byte, the end result
   typedef struct packed {
      result_type first;
      logic       has_end;
      result_type end_res;
   } entry_type;

endpackage

FILE: rtl/irc_tok_core.sv
module irc_tok_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            in_byte,
   input  logic                  last_byte,
   output irc_tok_pkg::entry_type entry
);

   irc_tok_pkg::phase_type phase_ff, phase_in;
   logic       after_space_ff, after_space_in;
   logic       prefix_content_ff, prefix_content_in;
   logic [3:0] param_count_ff, param_count_in;
   logic       overflow_ff, overflow_in;

   logic is_space;
   logic is_colon;
   logic end_bad;
   irc_tok_pkg::fld_type end_fld;
   irc_tok_pkg::result_type r0;

   assign is_space = (in_byte == irc_tok_pkg::CHAR_SPACE);
   assign is_colon = (in_byte == irc_tok_pkg::CHAR_COLON);

   always_comb begin
      phase_in          = phase_ff;
      after_space_in    = after_space_ff;
      prefix_content_in = prefix_content_ff;
      param_count_in    = param_count_ff;
      overflow_in       = overflow_ff;
      r0.data      = 8'd0;
      r0.evt       = irc_tok_pkg::EV_DROP;
      r0.fld       = irc_tok_pkg::FLD_PREFIX;
      r0.idx       = 4'd0;
      r0.malformed = 1'b0;
      r0.eor       = 1'b0;
      unique case (phase_ff)
         irc_tok_pkg::PH_START: begin
            if (is_colon) begin
               r0.evt            = irc_tok_pkg::EV_DROP;
               r0.fld            = irc_tok_pkg::FLD_PREFIX;
               phase_in          = irc_tok_pkg::PH_PREFIX;
               prefix_content_in = 1'b0;
            end else if (is_space) begin
               r0.evt         = irc_tok_pkg::EV_CLOSE;
               r0.fld         = irc_tok_pkg::FLD_COMMAND;
               phase_in       = irc_tok_pkg::PH_PARAM;
               after_space_in = 1'b1;
            end else begin
               r0.data        = in_byte;
               r0.evt         = irc_tok_pkg::EV_CONTENT;
               r0.fld         = irc_tok_pkg::FLD_COMMAND;
               phase_in       = irc_tok_pkg::PH_COMMAND;
               after_space_in = 1'b0;
            end
         end
         irc_tok_pkg::PH_PREFIX: begin
            if (is_space) begin
               r0.evt = irc_tok_pkg::EV_CLOSE;
               r0.fld = irc_tok_pkg::FLD_PREFIX;
               if (prefix_content_ff) begin
                  phase_in       = irc_tok_pkg::PH_COMMAND;
                  after_space_in = 1'b1;
               end else begin
                  r0.malformed = 1'b1;
                  phase_in     = irc_tok_pkg::PH_BAD;
               end
            end else begin
               r0.data           = in_byte;
               r0.evt            = irc_tok_pkg::EV_CONTENT;
               r0.fld            = irc_tok_pkg::FLD_PREFIX;
               prefix_content_in = 1'b1;
            end
         end
         irc_tok_pkg::PH_COMMAND: begin
            if (is_space) begin
               r0.evt         = irc_tok_pkg::EV_CLOSE;
               r0.fld         = irc_tok_pkg::FLD_COMMAND;
               phase_in       = irc_tok_pkg::PH_PARAM;
               after_space_in = 1'b1;
            end else if (is_colon && after_space_ff) begin
               r0.evt         = irc_tok_pkg::EV_DROP;
               r0.fld         = irc_tok_pkg::FLD_TRAIL;
               phase_in       = irc_tok_pkg::PH_TRAIL;
               after_space_in = 1'b0;
            end else begin
               r0.data        = in_byte;
               r0.evt         = irc_tok_pkg::EV_CONTENT;
               r0.fld         = irc_tok_pkg::FLD_COMMAND;
               after_space_in = 1'b0;
            end
         end
         irc_tok_pkg::PH_PARAM: begin
            if (is_space) begin
               r0.evt = irc_tok_pkg::EV_CLOSE;
               r0.fld = irc_tok_pkg::FLD_PARAM;
               r0.idx = param_count_ff;
               // saturate the index and flag the overflow instead
               if (param_count_ff < irc_tok_pkg::IDX_LIMIT) begin
                  param_count_in = param_count_ff + 4'd1;
               end else begin
                  overflow_in = 1'b1;
               end
               after_space_in = 1'b1;
            end else if (is_colon && after_space_ff) begin
               r0.evt         = irc_tok_pkg::EV_DROP;
               r0.fld         = irc_tok_pkg::FLD_TRAIL;
               phase_in       = irc_tok_pkg::PH_TRAIL;
               after_space_in = 1'b0;
            end else begin
               r0.data        = in_byte;
               r0.evt         = irc_tok_pkg::EV_CONTENT;
               r0.fld         = irc_tok_pkg::FLD_PARAM;
               r0.idx         = param_count_ff;
               after_space_in = 1'b0;
            end
         end
         irc_tok_pkg::PH_TRAIL: begin
            r0.data = in_byte;
            r0.evt  = irc_tok_pkg::EV_CONTENT;
            r0.fld  = irc_tok_pkg::FLD_TRAIL;
         end
         default: begin
            r0.evt       = irc_tok_pkg::EV_DROP;
            r0.fld       = irc_tok_pkg::FLD_PREFIX;
            r0.malformed = 1'b1;
            phase_in     = irc_tok_pkg::PH_BAD;
         end
      endcase
      r0.overflow = overflow_in;
   end

   // end result looks at the state this byte leaves behind
   always_comb begin
      end_bad = (phase_in == irc_tok_pkg::PH_BAD) ||
                ((phase_in == irc_tok_pkg::PH_PREFIX) && !prefix_content_in);
      if (end_bad) begin
         end_fld = irc_tok_pkg::FLD_PREFIX;
      end else begin
         unique case (phase_in)
            irc_tok_pkg::PH_START:   end_fld = irc_tok_pkg::FLD_COMMAND;
            irc_tok_pkg::PH_COMMAND: end_fld = irc_tok_pkg::FLD_COMMAND;
            irc_tok_pkg::PH_PARAM:   end_fld = irc_tok_pkg::FLD_PARAM;
            irc_tok_pkg::PH_TRAIL:   end_fld = irc_tok_pkg::FLD_TRAIL;
            default:                 end_fld = irc_tok_pkg::FLD_PREFIX;
         endcase
      end
      entry.first             = r0;
      entry.has_end           = last_byte;
      entry.end_res.data      = 8'd0;
      entry.end_res.evt       = irc_tok_pkg::EV_END;
      entry.end_res.fld       = end_fld;
      entry.end_res.idx       = (end_fld == irc_tok_pkg::FLD_PARAM) ? param_count_in : 4'd0;
      entry.end_res.malformed = end_bad;
      entry.end_res.overflow  = overflow_in;
      entry.end_res.eor       = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && last_byte)) begin
         phase_ff          <= irc_tok_pkg::PH_START;
         after_space_ff    <= 1'b0;
         prefix_content_ff <= 1'b0;
         param_count_ff    <= 4'd0;
         overflow_ff       <= 1'b0;
      end else if (fire) begin
         phase_ff          <= phase_in;
         after_space_ff    <= after_space_in;
         prefix_content_ff <= prefix_content_in;
         param_count_ff    <= param_count_in;
         overflow_ff       <= overflow_in;
      end
   end

endmodule

FILE: rtl/irc_tok_out.sv
`include "irc_message_tokenizer_defines.svh"

module irc_tok_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_i,
   input  irc_tok_pkg::entry_type entry_i,
   output logic                   room_o,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,  // out_byte[7:0], param_index[11:8],
                                              // malformed[12], param_overflow[13]
   output logic [3:0]             rsp_tuser,  // event_res[1:0], field[3:2]
   output logic                   rsp_tlast   // end_of_run
);

   irc_tok_pkg::entry_type  entry_ff;
   logic                    valid_ff;
   logic                    sub_ff;
   irc_tok_pkg::result_type out_res;
   logic                    xfer;
   logic                    done;

   assign out_res = sub_ff ? entry_ff.end_res : entry_ff.first;
   assign xfer    = valid_ff && rsp_tready;
   // entry leaves with its last result
   assign done    = xfer && (sub_ff || !entry_ff.has_end);
   assign room_o  = !valid_ff || done;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, out_res.overflow, out_res.malformed, out_res.idx, out_res.data};
   assign rsp_tuser  = {out_res.fld, out_res.evt};
   assign rsp_tlast  = out_res.eor;

   always_ff @(posedge clock) begin
      if (load_i) begin
         entry_ff <= entry_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else if (load_i) begin
         valid_ff <= 1'b1;
         sub_ff   <= 1'b0;
      end else if (done) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else if (xfer) begin
         sub_ff <= 1'b1;
      end
   end

   `IRC_ASSERT_NOW(a_sub_needs_end, sub_ff, valid_ff && entry_ff.has_end, "end phase without end result")
   `IRC_ASSERT_NOW(a_tlast_is_end, valid_ff && rsp_tlast, sub_ff && (out_res.evt == irc_tok_pkg::EV_END), "tlast on non-end result")
   `IRC_ASSERT_NEXT(a_first_then_end, xfer && !sub_ff && entry_ff.has_end, valid_ff && sub_ff, "end result lost after first")
   `IRC_ASSERT_NOW(a_no_overwrite, load_i, !valid_ff || done, "entry overwritten before delivery")

endmodule

FILE: rtl/irc_message_tokenizer.sv
// IRC message line tokenizer.
// req_*: one octet of a message line per transaction (CR LF removed),
//   req_tdata[7:0] the octet, req_tlast set on the final octet.
// rsp_*: one result per octet telling which part it belongs to (prefix,
//   command, numbered parameter, trail) and whether it is content, a part
//   close or a dropped delimiter. The final octet adds a second result,
//   the message end, marked with rsp_tlast.
// A result is registered twice on its way out: its octet passes the input
//   register, then the tokenizer state update into the result register.
// Throughput: one octet per cycle while the receiver takes results; the
//   final octet of a message holds the result register until both of its
//   results are taken, one after the other.
// The rate is set by the phase update in the tokenizer core, done per octet.
// Reset empties the input and result registers and returns the tokenizer to
//   the start of a message; state also returns there after every final octet.
// When the receiver stalls, the pending result holds, the input register
//   takes one more octet and then req_tready drops until space frees up.
module irc_message_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte[7:0], param_index[11:8],
                                    // malformed[12], param_overflow[13]
   output logic [3:0]  rsp_tuser,   // event_res[1:0], field[3:2]
   output logic        rsp_tlast    // end_of_run
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       room;
   logic       fire;
   irc_tok_pkg::entry_type entry;

   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   irc_tok_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .in_byte   (in_byte_ff),
      .last_byte (in_last_ff),
      .entry     (entry)
   );

   irc_tok_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load_i     (fire),
      .entry_i    (entry),
      .room_o     (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
